// ===== rtl/frcs_pkg.sv =====
// package for the fractional rate callback scheduler
// types, codes and constants shared by the front, queue, back and top level
package frcs_pkg;

  localparam int MAX_ENTRIES   = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int TICK_W        = 32;
  localparam int ID_W          = 8;
  localparam int RATE_W        = 8;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 40;

  localparam logic [RATE_W-1:0] BASE_RATE_RESET = 8'd50;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_EN  = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FIRED     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [RATE_W-1:0] rate;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   hnd;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] credit;
  } entry_t;

endpackage

// ===== rtl/frcs_front.sv =====
// front end: decodes incoming commands into queue items
// saturates add rates above the base rate, and a zero add rate, to the base rate; depends on frcs_pkg
module frcs_front (
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [frcs_pkg::IN_DATA_W-1:0] s_axis_tdata_i, // handler_id, rate
  input  logic [frcs_pkg::CMD_W-1:0]   s_axis_tuser_i,   // command
  input  logic [frcs_pkg::RATE_W-1:0]  base_rate_i,
  input  logic                         timer_en_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output frcs_pkg::item_t              q_item_o
);

  logic [frcs_pkg::ID_W-1:0]   id;
  logic [frcs_pkg::RATE_W-1:0] rate;

  assign id   = s_axis_tdata_i[frcs_pkg::ID_W-1:0];
  assign rate = s_axis_tdata_i[frcs_pkg::ID_W +: frcs_pkg::RATE_W];

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_item_o.id   = id;
    q_item_o.rate = rate;
    unique case (s_axis_tuser_i)
      frcs_pkg::CMD_TICK: begin
        q_item_o.op = timer_en_i ? frcs_pkg::OP_TICK : frcs_pkg::OP_NOP;
      end
      frcs_pkg::CMD_ADD: begin
        q_item_o.op = frcs_pkg::OP_ADD;
        if (rate == '0 || rate > base_rate_i) begin
          q_item_o.rate = base_rate_i;
        end
      end
      frcs_pkg::CMD_REMOVE: q_item_o.op = frcs_pkg::OP_REMOVE;
      frcs_pkg::CMD_CLEAR:  q_item_o.op = frcs_pkg::OP_CLEAR;
      default:              q_item_o.op = frcs_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== rtl/frcs_fifo.sv =====
// short queue of decoded items between front and back
// depends on frcs_pkg for the item type and depth
module frcs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  frcs_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output frcs_pkg::item_t item_o
);

  localparam int Depth = frcs_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  frcs_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/frcs_back.sv =====
// back end: handler table, tick counter, table walk and output register
// the table rotates through its head once per walk; depends on frcs_pkg
module frcs_back #(
  parameter int MaxEntries = frcs_pkg::MAX_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [frcs_pkg::RATE_W-1:0]     base_rate_i,
  input  logic                            item_valid_i,
  input  frcs_pkg::item_t                 item_i,
  output logic                            item_pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [frcs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o, // fired_handler, tick_count
  output logic [frcs_pkg::STATUS_W-1:0]   m_axis_tuser_o, // status
  output logic                            m_axis_tlast_o
);

  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int IdW  = frcs_pkg::ID_W;
  localparam int RW   = frcs_pkg::RATE_W;
  localparam int TW   = frcs_pkg::TICK_W;

  frcs_pkg::back_state_e state_q, state_d;
  frcs_pkg::entry_t      tbl_q [MaxEntries];
  frcs_pkg::entry_t      head, head_new;
  frcs_pkg::entry_t      add_entry;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic [TW-1:0]   ticks_q, ticks_d;
  logic            walk_rm_q, walk_rm_d;
  logic            found_q, found_d;
  logic [IdW-1:0]  id_q, id_d;
  logic            pend_v_q, pend_v_d;
  logic [IdW-1:0]  pend_q, pend_d;

  logic            out_v_q;
  logic [frcs_pkg::STATUS_W-1:0] out_status_q;
  logic [IdW-1:0]  out_hnd_q;
  logic [TW-1:0]   out_ticks_q;
  logic            out_last_q;

  logic            out_free;
  logic            emit_v, emit_last;
  frcs_pkg::status_e emit_status;
  logic [IdW-1:0]  emit_hnd;
  logic [TW-1:0]   emit_ticks;
  logic            do_add, do_step, keep;
  logic            fire;
  logic [RW-1:0]   cred_dec;
  logic [CntW-1:0] wr_pos;

  assign head     = tbl_q[0];
  assign fire     = (head.credit <= head.rate);
  assign cred_dec = head.credit - head.rate;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign wr_pos   = cnt_q - CntW'(1);

  always_comb begin
    add_entry.hnd    = item_i.id;
    add_entry.rate   = item_i.rate;
    add_entry.credit = base_rate_i;
  end

  always_comb begin
    head_new = head;
    if (!walk_rm_q) begin
      head_new.credit = fire ? cred_dec + base_rate_i : cred_dec;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    ticks_d     = ticks_q;
    walk_rm_d   = walk_rm_q;
    found_d     = found_q;
    id_d        = id_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    item_pop_o  = 1'b0;
    emit_v      = 1'b0;
    emit_status = frcs_pkg::STATUS_DONE;
    emit_hnd    = '0;
    emit_ticks  = ticks_q;
    emit_last   = 1'b1;
    do_add      = 1'b0;
    do_step     = 1'b0;
    keep        = 1'b1;
    unique case (state_q)
      frcs_pkg::ST_IDLE: begin
        if (item_valid_i && out_free) begin
          item_pop_o = 1'b1;
          unique case (item_i.op)
            frcs_pkg::OP_CLEAR: begin
              ticks_d    = '0;
              emit_v     = 1'b1;
              emit_ticks = '0;
            end
            frcs_pkg::OP_ADD: begin
              emit_v = 1'b1;
              if (cnt_q == CntW'(MaxEntries)) begin
                emit_status = frcs_pkg::STATUS_FULL;
              end else begin
                do_add = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            frcs_pkg::OP_REMOVE: begin
              if (cnt_q == '0) begin
                emit_v      = 1'b1;
                emit_status = frcs_pkg::STATUS_NOT_FOUND;
              end else begin
                state_d   = frcs_pkg::ST_WALK;
                walk_rm_d = 1'b1;
                found_d   = 1'b0;
                id_d      = item_i.id;
                steps_d   = cnt_q;
              end
            end
            frcs_pkg::OP_TICK: begin
              ticks_d = ticks_q + TW'(1);
              if (cnt_q == '0) begin
                emit_v     = 1'b1;
                emit_ticks = ticks_q + TW'(1);
              end else begin
                state_d   = frcs_pkg::ST_WALK;
                walk_rm_d = 1'b0;
                pend_v_d  = 1'b0;
                steps_d   = cnt_q;
              end
            end
            default: emit_v = 1'b1;
          endcase
        end
      end
      frcs_pkg::ST_WALK: begin
        if (walk_rm_q) begin
          do_step = 1'b1;
          if (head.hnd == id_q && !found_q) begin
            keep    = 1'b0;
            found_d = 1'b1;
            cnt_d   = cnt_q - CntW'(1);
          end
        end else if (!(fire && pend_v_q && !out_free)) begin
          do_step = 1'b1;
          if (fire) begin
            if (pend_v_q) begin
              emit_v      = 1'b1;
              emit_status = frcs_pkg::STATUS_FIRED;
              emit_hnd    = pend_q;
              emit_last   = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = head.hnd;
          end
        end
        if (do_step) begin
          steps_d = steps_q - CntW'(1);
          if (steps_q == CntW'(1)) begin
            state_d = frcs_pkg::ST_FINISH;
          end
        end
      end
      frcs_pkg::ST_FINISH: begin
        if (out_free) begin
          emit_v  = 1'b1;
          state_d = frcs_pkg::ST_IDLE;
          if (walk_rm_q) begin
            emit_status = found_q ? frcs_pkg::STATUS_DONE : frcs_pkg::STATUS_NOT_FOUND;
          end else if (pend_v_q) begin
            emit_status = frcs_pkg::STATUS_FIRED;
            emit_hnd    = pend_q;
          end
        end
      end
      default: state_d = frcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= frcs_pkg::ST_IDLE;
      cnt_q     <= '0;
      steps_q   <= '0;
      ticks_q   <= '0;
      walk_rm_q <= 1'b0;
      found_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      steps_q   <= steps_d;
      ticks_q   <= ticks_d;
      walk_rm_q <= walk_rm_d;
      found_q   <= found_d;
      pend_v_q  <= pend_v_d;
      if (emit_v) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    pend_q <= pend_d;
    if (emit_v) begin
      out_status_q <= emit_status;
      out_hnd_q    <= emit_hnd;
      out_ticks_q  <= emit_ticks;
      out_last_q   <= emit_last;
    end
  end

  // table cells: add shifts toward the tail, a walk step rotates the head to the tail
  for (genvar j = 0; j < MaxEntries; j++) begin : g_cell
    localparam logic [CntW-1:0] Pos = CntW'(j);
    always_ff @(posedge clk_i) begin
      if (do_add) begin
        if (j == 0) begin
          tbl_q[j] <= add_entry;
        end else begin
          tbl_q[j] <= tbl_q[(j > 0) ? j - 1 : 0];
        end
      end else if (do_step) begin
        if (keep && Pos == wr_pos) begin
          tbl_q[j] <= head_new;
        end else if (j < MaxEntries - 1) begin
          tbl_q[j] <= tbl_q[(j < MaxEntries - 1) ? j + 1 : j];
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_ticks_q, out_hnd_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/fractional_rate_callback_scheduler.sv =====
// add, clear, disabled tick, and tick or remove on an empty table give one result each;
// tick and remove walk the table one entry per cycle, a tick walk holding while a fired
// handler waits for a busy output, through the single rotating table head in the back end
// a two-entry queue lets the front accept while the back walks
// reset: table empty, tick count zero, base_rate 50, timer off; entry storage is not cleared
module fractional_rate_callback_scheduler #(
  parameter int MaxEntries = frcs_pkg::MAX_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [frcs_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // handler_id, rate
  input  logic [frcs_pkg::CMD_W-1:0]       s_axis_tuser_i,  // command
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [frcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,  // fired_handler, tick_count
  output logic [frcs_pkg::STATUS_W-1:0]    m_axis_tuser_o,  // status
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_we_i,
  input  logic [frcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [frcs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [frcs_pkg::RATE_W-1:0] base_rate_q;
  logic                        timer_en_q;
  logic                        q_full, q_push, q_valid, q_pop;
  frcs_pkg::item_t             q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_rate_q <= frcs_pkg::BASE_RATE_RESET;
      timer_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frcs_pkg::CFG_BASE_RATE: base_rate_q <= cfg_data_i[frcs_pkg::RATE_W-1:0];
        frcs_pkg::CFG_TIMER_EN:  timer_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  frcs_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .base_rate_i     (base_rate_q),
    .timer_en_i      (timer_en_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  frcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  frcs_back #(
    .MaxEntries (MaxEntries)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .base_rate_i     (base_rate_q),
    .item_valid_i    (q_valid),
    .item_i          (q_out),
    .item_pop_o      (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
